// ----- rtl/itrg_pkg.sv -----
// Shared types and constants for the image tile rectangle generator.
package itrg_pkg;

  // Field widths of the descriptor, the configuration and the tiles.
  localparam int ORIGIN_W = 16;
  localparam int DIM_W    = 12;
  localparam int POS_W    = 17;

  // Tile counts per axis are held minus one; the cap never exceeds eight.
  localparam int CNT_W = 3;
  localparam int MAX_TILES_PER_AXIS_DEF = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIM_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 1'b1;

  // Job queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // One classified image, ready to be cut into tiles.
  typedef struct packed {
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [DIM_W-1:0]    step_w;
    logic [DIM_W-1:0]    step_h;
    logic [DIM_W-1:0]    last_w;
    logic [DIM_W-1:0]    last_h;
    logic [CNT_W-1:0]    col_last;
    logic [CNT_W-1:0]    row_last;
    logic                compressed;
    logic                over;
  } job_t;

endpackage

// ----- rtl/itrg_if.sv -----
// Stream interfaces for image descriptors and tile rectangles.
interface itrg_in_if;
  import itrg_pkg::*;
  logic                valid;
  logic                ready;
  logic [ORIGIN_W-1:0] origin_x;
  logic [ORIGIN_W-1:0] origin_y;
  logic [DIM_W-1:0]    image_width;
  logic [DIM_W-1:0]    image_height;
  logic                compress_on;

  modport source (output valid, origin_x, origin_y, image_width, image_height,
                  compress_on, input ready);
  modport sink (input valid, origin_x, origin_y, image_width, image_height,
                compress_on, output ready);
endinterface

interface itrg_out_if;
  import itrg_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] tile_x;
  logic [POS_W-1:0] tile_y;
  logic [DIM_W-1:0] tile_w;
  logic [DIM_W-1:0] tile_h;
  logic             tile_compressed;
  logic             last_tile;
  logic             too_many_tiles;

  modport source (output valid, tile_x, tile_y, tile_w, tile_h, tile_compressed,
                  last_tile, too_many_tiles, input ready);
  modport sink (input valid, tile_x, tile_y, tile_w, tile_h, tile_compressed,
                last_tile, too_many_tiles, output ready);
endinterface

// ----- rtl/itrg_front.sv -----
// Front part: accepts descriptors and counts tiles per axis by repeated subtraction.
module itrg_front #(
  parameter int MAX_TILES_PER_AXIS = itrg_pkg::MAX_TILES_PER_AXIS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [itrg_pkg::DIM_W-1:0] tile_width,
  input  logic [itrg_pkg::DIM_W-1:0] tile_height,
  itrg_in_if.sink                in_ch,
  output logic                   push_valid,
  input  logic                   push_ready,
  output itrg_pkg::job_t         push_data
);
  import itrg_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_PUSH} state_t;

  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_TILES_PER_AXIS - 1);

  state_t              state;
  logic [ORIGIN_W-1:0] origin_x;
  logic [ORIGIN_W-1:0] origin_y;
  logic [DIM_W-1:0]    step_w;
  logic [DIM_W-1:0]    step_h;
  logic [DIM_W-1:0]    rem_w;
  logic [DIM_W-1:0]    rem_h;
  logic [CNT_W-1:0]    cnt_w;
  logic [CNT_W-1:0]    cnt_h;
  logic                done_w;
  logic                done_h;
  logic                compressed;
  logic                over;

  logic fit_w, fit_h, cap_w, cap_h, over_w, over_h, fin_w, fin_h;

  // The remaining width fits in one tile, or a further full tile breaks the cap.
  always_comb begin
    fit_w  = (rem_w <= step_w);
    fit_h  = (rem_h <= step_h);
    cap_w  = (cnt_w == CNT_CAP);
    cap_h  = (cnt_h == CNT_CAP);
    over_w = !done_w && !fit_w && cap_w;
    over_h = !done_h && !fit_h && cap_h;
    fin_w  = done_w || fit_w;
    fin_h  = done_h || fit_h;
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign push_valid  = (state == ST_PUSH);

  always_comb begin
    push_data.origin_x   = origin_x;
    push_data.origin_y   = origin_y;
    push_data.step_w     = step_w;
    push_data.step_h     = step_h;
    push_data.last_w     = rem_w;
    push_data.last_h     = rem_h;
    push_data.col_last   = cnt_w;
    push_data.row_last   = cnt_h;
    push_data.compressed = compressed;
    push_data.over       = over;
  end

  // Control sequence and the per-axis subtraction registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            origin_x   <= in_ch.origin_x;
            origin_y   <= in_ch.origin_y;
            step_w     <= tile_width;
            step_h     <= tile_height;
            rem_w      <= in_ch.image_width;
            rem_h      <= in_ch.image_height;
            cnt_w      <= '0;
            cnt_h      <= '0;
            done_w     <= 1'b0;
            done_h     <= 1'b0;
            compressed <= in_ch.compress_on;
            over       <= 1'b0;
            // An empty image gives no tiles; tiling switched off gives one.
            if (in_ch.image_width == '0 || in_ch.image_height == '0) begin
              state <= ST_IDLE;
            end else if (tile_width == '0 || tile_height == '0) begin
              state <= ST_PUSH;
            end else begin
              state <= ST_DIVIDE;
            end
          end
        end
        ST_DIVIDE: begin
          if (!done_w) begin
            if (fit_w) begin
              done_w <= 1'b1;
            end else if (!cap_w) begin
              rem_w <= rem_w - step_w;
              cnt_w <= cnt_w + CNT_W'(1);
            end
          end
          if (!done_h) begin
            if (fit_h) begin
              done_h <= 1'b1;
            end else if (!cap_h) begin
              rem_h <= rem_h - step_h;
              cnt_h <= cnt_h + CNT_W'(1);
            end
          end
          if (over_w || over_h) begin
            over  <= 1'b1;
            state <= ST_PUSH;
          end else if (fin_w && fin_h) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/itrg_queue.sv -----
// Two-entry job queue between the front and back parts.
module itrg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  itrg_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output itrg_pkg::job_t pop_data
);
  import itrg_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/itrg_back.sv -----
// Back part: walks a job row by row and column by column, one tile per cycle while the output is not stalled.
module itrg_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  itrg_pkg::job_t pop_data,
  itrg_out_if.source     out_ch
);
  import itrg_pkg::*;

  logic             busy;
  job_t             job;
  logic [CNT_W-1:0] col;
  logic [CNT_W-1:0] row;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic             out_free;
  logic             end_col;
  logic             end_row;

  assign pop_ready = !busy;
  assign out_free  = !out_ch.valid || out_ch.ready;
  assign end_col   = (col == job.col_last);
  assign end_row   = (row == job.row_last);

  // Job walk and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      // Take the next job once the previous one is done.
      if (!busy && pop_valid) begin
        job   <= pop_data;
        col   <= '0;
        row   <= '0;
        pos_x <= POS_W'(pop_data.origin_x);
        pos_y <= POS_W'(pop_data.origin_y);
        busy  <= 1'b1;
      end
      // Load the next tile when the output register is free; otherwise drop a taken tile.
      if (busy && out_free) begin
        out_ch.valid           <= 1'b1;
        out_ch.tile_compressed <= job.compressed;
        if (job.over) begin
          // Over the cap: a single flagged result with zero geometry.
          out_ch.tile_x         <= '0;
          out_ch.tile_y         <= '0;
          out_ch.tile_w         <= '0;
          out_ch.tile_h         <= '0;
          out_ch.last_tile      <= 1'b1;
          out_ch.too_many_tiles <= 1'b1;
          busy                  <= 1'b0;
        end else begin
          out_ch.tile_x         <= pos_x;
          out_ch.tile_y         <= pos_y;
          out_ch.tile_w         <= end_col ? job.last_w : job.step_w;
          out_ch.tile_h         <= end_row ? job.last_h : job.step_h;
          out_ch.last_tile      <= end_col && end_row;
          out_ch.too_many_tiles <= 1'b0;
          if (end_col && end_row) begin
            busy <= 1'b0;
          end else if (end_col) begin
            col   <= '0;
            row   <= row + CNT_W'(1);
            pos_x <= POS_W'(job.origin_x);
            pos_y <= pos_y + POS_W'(job.step_h);
          end else begin
            col   <= col + CNT_W'(1);
            pos_x <= pos_x + POS_W'(job.step_w);
          end
        end
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/image_tile_rectangle_generator.sv -----
// A descriptor is accepted, the front part counts its tiles per axis by repeated
// subtraction (both axes in parallel) and pushes one job into the queue. The back part
// takes each job from the queue and emits one tile per cycle when the output is not
// stalled, up to MAX_TILES_PER_AXIS**2 tiles per image; meanwhile the front part can
// work on the next image. Reset (synchronous, active high) clears the tile size
// registers, the queue and both control sequences; no memory needs clearing.
module image_tile_rectangle_generator #(
  parameter int MAX_TILES_PER_AXIS = itrg_pkg::MAX_TILES_PER_AXIS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [itrg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [itrg_pkg::CFG_DATA_W-1:0] cfg_data,
  itrg_in_if.sink                         in_ch,
  itrg_out_if.source                      out_ch
);
  import itrg_pkg::*;

  logic [DIM_W-1:0] tile_width;
  logic [DIM_W-1:0] tile_height;
  logic             push_valid;
  logic             push_ready;
  job_t             push_data;
  logic             pop_valid;
  logic             pop_ready;
  job_t             pop_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width  <= '0;
      tile_height <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TILE_WIDTH:  tile_width  <= cfg_data;
        CFG_TILE_HEIGHT: tile_height <= cfg_data;
        default: ;
      endcase
    end
  end

  itrg_front #(
    .MAX_TILES_PER_AXIS(MAX_TILES_PER_AXIS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .tile_width (tile_width),
    .tile_height(tile_height),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  itrg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  itrg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .out_ch   (out_ch)
  );

endmodule
